### sv/bps_pkg.sv
// ---------------------------------------------------------------------------
// bps_pkg: shared types and constants of the buffer pitch search unit
// Request and response words and the fixed pixel format of the search.
// ---------------------------------------------------------------------------
package bps_pkg;

   // buffer dimensions are carried at a fixed width on the request word
   localparam int DIM_BITS = 14;

   // 32-bit pixels: byte pitch is pixel pitch shifted by this amount
   localparam int BPP_SHIFT = 2;

   localparam int PITCH_PX_BITS   = 16;
   localparam int BYTE_PITCH_BITS = 18;
   localparam int ALIGN_BITS      = 28;
   localparam int SIZE_BITS       = 35;

   typedef struct packed {
      logic [DIM_BITS-1:0] width_px;
      logic [DIM_BITS-1:0] height_px;
   } req_type;

   typedef struct packed {
      logic [PITCH_PX_BITS-1:0]   pitch_px;
      logic [BYTE_PITCH_BITS-1:0] byte_pitch;
      logic [ALIGN_BITS-1:0]      align_bytes;
      logic [SIZE_BITS-1:0]       size_bytes;
   } rsp_type;

endpackage

### sv/bps_step_unit.sv
// ---------------------------------------------------------------------------
// bps_step_unit: candidate evaluation unit
// For one pixel pitch computes lcm(byte pitch, page), the effective size,
// the waste and whether the candidate beats the best effective size so far.
// ---------------------------------------------------------------------------
module bps_step_unit #(
   parameter int PW = 15,
   parameter int PS = 12,
   parameter int EW = 33
) (
   input  logic [PW-1:0] pitch,
   input  logic [EW-1:0] row_bytes,
   input  logic [EW-1:0] pad_bytes,
   input  logic [EW-1:0] best_eff,
   output logic [EW-1:0] lcm_bytes,
   output logic [EW-1:0] eff_bytes,
   output logic [EW-1:0] waste_bytes,
   output logic          better
);
   import bps_pkg::*;

   localparam int TZW = $clog2(PW + 1);
   localparam int SHW = $clog2(PS);

   logic [TZW-1:0] tz;
   logic [SHW-1:0] sh;
   logic [EW-1:0]  bytes;

   // lowest set bit of the pixel pitch
   always_comb begin
      tz = '0;
      for (int i = PW - 1; i >= 0; i--) begin
         if (pitch[i]) begin
            tz = TZW'(i);
         end
      end
   end

   always_comb begin
      if (int'(tz) >= PS - BPP_SHIFT) begin
         sh = '0;
      end else begin
         sh = SHW'(PS - BPP_SHIFT - int'(tz));
      end
   end

   assign bytes       = EW'(pitch) << BPP_SHIFT;
   assign lcm_bytes   = (pitch == '0) ? '0 : (bytes << sh);
   assign eff_bytes   = lcm_bytes + row_bytes;
   assign waste_bytes = lcm_bytes + pad_bytes;
   assign better      = eff_bytes < best_eff;

endmodule

### sv/buffer_pitch_search_unit.sv
// ---------------------------------------------------------------------------
// buffer_pitch_search_unit: frame buffer row pitch search
// Walks pixel pitches upward from the width, one candidate a cycle, and
// keeps the pitch of smallest lcm(4p, page) + 4*p*height.
// ---------------------------------------------------------------------------
//  channel  | ports                      | handshake
//  request  | start, busy, req_data      | word taken when start && !busy
//  response | rsp_strobe, rsp_data       | word valid for one cycle on strobe
//
//  after acceptance the unit runs init, prime, the loop over N pitches and
//  out before the response strobe, where N is the number of pitches tried
//  (the search stops once the padding reaches the best waste, or after
//  PAGE_BYTES/2 pitches); the evaluation unit handles one pitch per cycle
//  busy is low again in the cycle that shows the response
//  synchronous reset returns the sequencer to idle and drops the strobe
//  the response side has no stall
// ---------------------------------------------------------------------------
module buffer_pitch_search_unit #(
   parameter int PAGE_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bps_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bps_pkg::rsp_type rsp_data
);
   import bps_pkg::*;

   localparam int PS   = $clog2(PAGE_BYTES);
   localparam int SPAN = PAGE_BYTES / 2;
   localparam int PW   = ((DIM_BITS > PS - 1) ? DIM_BITS : PS - 1) + 1;
   localparam int BW   = PW + BPP_SHIFT;
   localparam int LW   = BW + PS - BPP_SHIFT;
   localparam int EW   = ((LW > BW + DIM_BITS) ? LW : BW + DIM_BITS) + 1;
   localparam int OW   = PS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_PRIME = 3'd2;
   localparam logic [2:0] ST_LOOP  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [DIM_BITS-1:0] w_ff, w_in;
   logic [DIM_BITS-1:0] h_ff, h_in;
   logic [PW-1:0]       p_ff, p_in;
   logic [OW-1:0]       off_ff, off_in;
   logic [EW-1:0]       pad_ff, pad_in;
   logic [EW-1:0]       ph_ff, ph_in;
   logic [PW-1:0]       best_ff, best_in;
   logic [EW-1:0]       best_e_ff, best_e_in;
   logic [EW-1:0]       best_loss_ff, best_loss_in;
   logic [EW-1:0]       best_lcm_ff, best_lcm_in;
   logic [EW-1:0]       best_ph_ff, best_ph_in;
   logic                strobe_ff, strobe_in;
   rsp_type             rsp_ff, rsp_in;

   logic [EW-1:0] lcm_bytes;
   logic [EW-1:0] eff_bytes;
   logic [EW-1:0] waste_bytes;
   logic          better;
   logic [EW-1:0] step_bytes;
   logic          go_on;
   logic [EW:0]   size_sum;
   logic [EW:0]   size_round;

   bps_step_unit #(
      .PW (PW),
      .PS (PS),
      .EW (EW)
   ) u_step (
      .pitch       (p_ff),
      .row_bytes   (ph_ff),
      .pad_bytes   (pad_ff),
      .best_eff    (best_e_ff),
      .lcm_bytes   (lcm_bytes),
      .eff_bytes   (eff_bytes),
      .waste_bytes (waste_bytes),
      .better      (better)
   );

   assign step_bytes = EW'(h_ff) << BPP_SHIFT;
   assign go_on      = (pad_ff < best_loss_ff) && (off_ff < OW'(SPAN));

   // round the buffer size up to whole pages
   assign size_sum   = (EW + 1)'(best_ph_ff) + (EW + 1)'(PAGE_BYTES - 1);
   assign size_round = size_sum & ~(EW + 1)'(PAGE_BYTES - 1);

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      p_in         = p_ff;
      off_in       = off_ff;
      pad_in       = pad_ff;
      ph_in        = ph_ff;
      best_in      = best_ff;
      best_e_in    = best_e_ff;
      best_loss_in = best_loss_ff;
      best_lcm_in  = best_lcm_ff;
      best_ph_in   = best_ph_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               w_in     = req_data.width_px;
               h_in     = req_data.height_px;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            p_in     = PW'(w_ff);
            off_in   = '0;
            pad_in   = '0;
            ph_in    = (EW'(w_ff) * EW'(h_ff)) << BPP_SHIFT;
            state_in = ST_PRIME;
         end
         ST_PRIME: begin
            // the width itself is the first best candidate
            best_in      = p_ff;
            best_e_in    = eff_bytes;
            best_loss_in = waste_bytes;
            best_lcm_in  = lcm_bytes;
            best_ph_in   = ph_ff;
            p_in         = p_ff + PW'(1);
            off_in       = off_ff + OW'(1);
            pad_in       = pad_ff + step_bytes;
            ph_in        = ph_ff + step_bytes;
            state_in     = ST_LOOP;
         end
         ST_LOOP: begin
            if (go_on) begin
               if (better) begin
                  best_in      = p_ff;
                  best_e_in    = eff_bytes;
                  best_loss_in = waste_bytes;
                  best_lcm_in  = lcm_bytes;
                  best_ph_in   = ph_ff;
               end
               p_in   = p_ff + PW'(1);
               off_in = off_ff + OW'(1);
               pad_in = pad_ff + step_bytes;
               ph_in  = ph_ff + step_bytes;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_in.pitch_px    = PITCH_PX_BITS'(best_ff);
            rsp_in.byte_pitch  = BYTE_PITCH_BITS'(BW'(best_ff) << BPP_SHIFT);
            rsp_in.align_bytes = ALIGN_BITS'(best_lcm_ff);
            rsp_in.size_bytes  = SIZE_BITS'(size_round);
            strobe_in          = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      h_ff         <= h_in;
      p_ff         <= p_in;
      off_ff       <= off_in;
      pad_ff       <= pad_in;
      ph_ff        <= ph_in;
      best_ff      <= best_in;
      best_e_ff    <= best_e_in;
      best_loss_ff <= best_loss_in;
      best_lcm_ff  <= best_lcm_in;
      best_ph_ff   <= best_ph_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### sv/bps_checker.sv
// ---------------------------------------------------------------------------
// bps_checker: port-level checks of the buffer pitch search unit
// Watches the command handshake and the response strobe over time.
// ---------------------------------------------------------------------------
module bps_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input bps_pkg::rsp_type rsp_data
);
   import bps_pkg::*;

   // an accepted word keeps the unit busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // a response word shows for one cycle only
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // busy drops exactly when the response word appears
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy dropped without a response word");

   // the response word never shows while the unit is still busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response word shown while busy");

   // byte pitch is four times the pixel pitch
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.byte_pitch ==
                      (BYTE_PITCH_BITS'(rsp_data.pitch_px) << BPP_SHIFT)))
      else $error("byte pitch does not match pixel pitch");

endmodule

bind buffer_pitch_search_unit bps_checker u_bps_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### bench/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for the buffer pitch search unit
// Drives buffer requests through the start/busy handshake and checks every
// response strobe against a pitch search computed in the bench.
// ---------------------------------------------------------------------------
module tb;
   import bps_pkg::*;

   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int DIM_MAX = (1 << DIM_BITS) - 1;
   localparam int RANDOM_WORDS = 580;
   localparam int DIRECTED_MAX = 25;
   // every word may walk the full search span, with room for sender gaps
   localparam longint CYCLE_LIMIT =
      longint'(DIRECTED_MAX + RANDOM_WORDS) * (PAGE_BYTES / 2 + 64) * 4 + 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type buffer_requests[$];
   rsp_type expected_pitches[$];
   logic    word_taken = 1'b0;
   int unsigned words_issued = 0;
   int unsigned responses_checked = 0;
   int unsigned zero_dim_words = 0;
   int unsigned mismatches = 0;
   longint  cycle_count = 0;

   buffer_pitch_search_unit #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // lcm with the page size: shift the byte count up by the missing zeros
   function automatic longint unsigned page_lcm(longint unsigned bytes);
      longint unsigned v;
      int tz;
      v = bytes;
      tz = 0;
      if (bytes == 0) return 0;
      while (!v[0] && tz < 63) begin
         v = v >> 1;
         tz++;
      end
      if (tz >= PAGE_SHIFT) return bytes;
      return bytes << (PAGE_SHIFT - tz);
   endfunction

   function automatic rsp_type search_pitch(req_type word);
      longint unsigned w, h, best, best_e, best_loss, p, e, pitch, size, align;
      rsp_type res;
      w = word.width_px;
      h = word.height_px;
      best = w;
      best_e = page_lcm(w << BPP_SHIFT) + ((w * h) << BPP_SHIFT);
      best_loss = page_lcm(w << BPP_SHIFT);
      // stop once the padding alone is as large as the best waste
      for (p = w; (((p - w) * h) << BPP_SHIFT) < best_loss && (p - w) < PAGE_BYTES / 2;
           p++) begin
         e = page_lcm(p << BPP_SHIFT) + ((p * h) << BPP_SHIFT);
         if (e < best_e) begin
            best = p;
            best_e = e;
            best_loss = page_lcm(p << BPP_SHIFT) + (((p - w) * h) << BPP_SHIFT);
         end
      end
      pitch = best << BPP_SHIFT;
      size = (pitch * h + PAGE_BYTES - 1) & ~(longint'(PAGE_BYTES) - 1);
      align = page_lcm(pitch);
      res.pitch_px = best[PITCH_PX_BITS-1:0];
      res.byte_pitch = pitch[BYTE_PITCH_BITS-1:0];
      res.align_bytes = align[ALIGN_BITS-1:0];
      res.size_bytes = size[SIZE_BITS-1:0];
      return res;
   endfunction

   task automatic queue_request(int unsigned w, int unsigned h);
      req_type word;
      word.width_px = w[DIM_BITS-1:0];
      word.height_px = h[DIM_BITS-1:0];
      if (word.width_px == 0 || word.height_px == 0) zero_dim_words++;
      buffer_requests = {buffer_requests, word};
   endtask

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // driver: a word stays until taken; random gaps, none for words 200-329
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         if (buffer_requests.size() > 0 &&
             ((words_issued >= 200 && words_issued < 330) ||
              $urandom_range(99) >= 18)) begin
            req_data <= buffer_requests.pop_front();
            start <= 1'b1;
            words_issued <= words_issued + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check the strobed word, then log the newly taken request
   always @(posedge clock) begin
      rsp_type want;
      word_taken <= !reset && start && !busy;
      if (!reset && rsp_strobe) begin
         if (expected_pitches.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending, pitch %0d",
                                      rsp_data.pitch_px));
         end else begin
            want = expected_pitches.pop_front();
            responses_checked++;
            if (rsp_data.pitch_px !== want.pitch_px)
               report_mismatch($sformatf("pitch_px got %0d want %0d",
                                         rsp_data.pitch_px, want.pitch_px));
            if (rsp_data.byte_pitch !== want.byte_pitch)
               report_mismatch($sformatf("byte_pitch got %0d want %0d",
                                         rsp_data.byte_pitch, want.byte_pitch));
            if (rsp_data.align_bytes !== want.align_bytes)
               report_mismatch($sformatf("align_bytes got %0d want %0d",
                                         rsp_data.align_bytes, want.align_bytes));
            if (rsp_data.size_bytes !== want.size_bytes)
               report_mismatch($sformatf("size_bytes got %0d want %0d",
                                         rsp_data.size_bytes, want.size_bytes));
         end
      end
      if (!reset && start && !busy)
         expected_pitches = {expected_pitches, search_pitch(req_data)};
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned roll, w, h;

      // corners of both dimensions, zero cases and page-aligned widths
      queue_request(0, 0);
      queue_request(0, 1);
      queue_request(0, DIM_MAX);
      queue_request(1, 0);
      queue_request(DIM_MAX, 0);
      queue_request(1023, 0);
      queue_request(1, 1);
      queue_request(DIM_MAX, DIM_MAX);
      queue_request(1, DIM_MAX);
      queue_request(DIM_MAX, 1);
      queue_request(1024, 1);
      queue_request(1024, DIM_MAX);
      queue_request(1023, 1);
      queue_request(1025, 7);
      queue_request(2048, 100);
      queue_request(3, 3);
      queue_request(8192, 8191);
      queue_request('h2aaa, 'h1555);
      queue_request('h1555, 'h2aaa);
      queue_request(511, 3);
      queue_request(768, 2);
      queue_request(15360, 16);
      queue_request(640, 480);
      queue_request(1920, 1080);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         roll = $urandom_range(99);
         w = $urandom_range(DIM_MAX, 1);
         h = $urandom_range(DIM_MAX, 1);
         if (roll < 2) w = 0;
         else if (roll < 4) h = 0;
         else if (roll < 16) h = $urandom_range(64, 1);
         else if (roll < 32) w = $urandom_range(64, 1);
         else if (roll < 45) w = $urandom_range(15, 1) * 1024 - $urandom_range(8);
         else if (roll < 55) w = $urandom_range(2047, 1) * 8;
         queue_request(w, h);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (buffer_requests.size() > 0 || start) @(posedge clock);
      while (expected_pitches.size() > 0) @(posedge clock);
      repeat (PAGE_BYTES / 2 + 16) @(posedge clock);

      if (expected_pitches.size() > 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_pitches.size()));
      $display("checked %0d responses for %0d requests, %0d with a zero dimension",
               responses_checked, words_issued, zero_dim_words);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
